[rtl/ihp_pkg.sv]
// Shared types, constants and state codes for the indexed max-heap.
`default_nettype none
package ihp_pkg;

  // Heap size and derived widths; slot 0 of the store is unused
  localparam int CAPACITY = 16;
  localparam int IDXW     = $clog2(CAPACITY + 1);
  localparam int DEPTH    = CAPACITY + 1;
  localparam int ID_W     = 10;
  localparam int KEY_W    = 32;
  localparam int FILL_W   = 5;

  // Operation codes
  localparam logic [1:0] FN_INSERT  = 2'd0;
  localparam logic [1:0] FN_MODIFY  = 2'd1;
  localparam logic [1:0] FN_EXTRACT = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Command word
  typedef struct packed {
    logic [1:0]       func;
    logic [ID_W-1:0]  item_id;
    logic [KEY_W-1:0] key;
  } ihp_in_t;

  // Result word
  typedef struct packed {
    logic [ID_W-1:0]   out_id;
    logic [1:0]        status;
    logic [FILL_W-1:0] fill;
  } ihp_out_t;

  // One heap slot as stored
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } ihp_entry_t;

  localparam int ENTRY_W = $bits(ihp_entry_t);

  // Store access from the sequencer
  typedef struct packed {
    logic            we;
    logic [IDXW-1:0] waddr;
    ihp_entry_t      wdata;
    logic [IDXW-1:0] raddr;
  } ihp_mem_req_t;

  // Completion of one command
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   out_id;
    logic [1:0]        status;
    logic [FILL_W-1:0] fill;
  } ihp_fin_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_ROOT,
    S_EX_LAST,
    S_EX_LOAD,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_MD_SCAN
  } ihp_state_t;

endpackage
`default_nettype wire

[rtl/ihp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ihp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/ihp_engine.sv]
// Heap sequencer: entry count, sift-up, sift-down and id search over the slot store.
`default_nettype none
module ihp_engine import ihp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire ihp_in_t      cmd,
  input  wire ihp_entry_t   rd_data,
  output logic              idle,
  output ihp_mem_req_t      mem,
  output ihp_fin_t          fin
);

  ihp_state_t       state, state_next;
  logic [IDXW-1:0]  count, count_next;
  logic [IDXW-1:0]  pos, pos_next;
  ihp_entry_t       ent, ent_next;
  ihp_entry_t       lft, lft_next;
  logic [ID_W-1:0]  oid, oid_next;
  logic [ID_W-1:0]  req_id, req_id_next;
  logic [KEY_W-1:0] req_key, req_key_next;
  logic [IDXW-1:0]  scan_addr, scan_addr_next;
  logic [IDXW-1:0]  chk_addr, chk_addr_next;
  logic             chk_valid, chk_valid_next;

  // child addresses, one bit wider than a slot index
  logic [IDXW:0] cnt_w, lidx, ridx;
  logic          has_right, use_right;
  ihp_entry_t    child;

  assign cnt_w     = {1'b0, count};
  assign lidx      = {1'b0, pos} << 1;
  assign ridx      = lidx + {{IDXW{1'b0}}, 1'b1};
  assign has_right = (ridx <= cnt_w);
  assign use_right = has_right && !(lft.key > rd_data.key);
  assign child     = use_right ? rd_data : lft;
  assign idle      = (state == S_IDLE);

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      chk_valid <= chk_valid_next;
    end
    pos       <= pos_next;
    ent       <= ent_next;
    lft       <= lft_next;
    oid       <= oid_next;
    req_id    <= req_id_next;
    req_key   <= req_key_next;
    scan_addr <= scan_addr_next;
    chk_addr  <= chk_addr_next;
  end

  // next state, store access and completion
  always_comb begin
    state_next     = state;
    count_next     = count;
    pos_next       = pos;
    ent_next       = ent;
    lft_next       = lft;
    oid_next       = oid;
    req_id_next    = req_id;
    req_key_next   = req_key;
    scan_addr_next = scan_addr;
    chk_addr_next  = chk_addr;
    chk_valid_next = chk_valid;

    mem.we    = 1'b0;
    mem.waddr = pos;
    mem.wdata = ent;
    mem.raddr = pos;

    fin.valid  = 1'b0;
    fin.out_id = '0;
    fin.status = ST_OK;
    fin.fill   = FILL_W'(count);

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.func)
            FN_INSERT: begin
              if (count == IDXW'(CAPACITY)) begin
                fin.valid  = 1'b1;
                fin.status = ST_FULL;
              end else begin
                count_next  = count + 1'b1;
                pos_next    = count + 1'b1;
                ent_next.id = cmd.item_id;
                ent_next.key = cmd.key;
                state_next  = S_UP_RD;
              end
            end
            FN_MODIFY: begin
              if (count == '0) begin
                fin.valid  = 1'b1;
                fin.status = ST_NOTFOUND;
              end else begin
                req_id_next    = cmd.item_id;
                req_key_next   = cmd.key;
                scan_addr_next = IDXW'(1);
                chk_valid_next = 1'b0;
                state_next     = S_MD_SCAN;
              end
            end
            FN_EXTRACT: begin
              if (count == '0) begin
                fin.valid  = 1'b1;
                fin.status = ST_EMPTY;
              end else begin
                state_next = S_EX_ROOT;
              end
            end
            default: begin
              // unused code: no operation
              fin.valid = 1'b1;
            end
          endcase
        end
      end

      // sift-up: fetch parent, or settle at the root
      S_UP_RD: begin
        if (pos == IDXW'(1)) begin
          mem.we     = 1'b1;
          fin.valid  = 1'b1;
          state_next = S_IDLE;
        end else begin
          mem.raddr  = pos >> 1;
          state_next = S_UP_CMP;
        end
      end

      // sift-up: parent moves down into the hole, or entry settles
      S_UP_CMP: begin
        mem.we = 1'b1;
        if (ent.key > rd_data.key) begin
          mem.wdata  = rd_data;
          pos_next   = pos >> 1;
          state_next = S_UP_RD;
        end else begin
          fin.valid  = 1'b1;
          state_next = S_IDLE;
        end
      end

      // extract: read root, then last slot
      S_EX_ROOT: begin
        mem.raddr  = IDXW'(1);
        state_next = S_EX_LAST;
      end

      S_EX_LAST: begin
        mem.raddr  = count;
        oid_next   = rd_data.id;
        count_next = count - 1'b1;
        state_next = S_EX_LOAD;
      end

      S_EX_LOAD: begin
        ent_next = rd_data;
        pos_next = IDXW'(1);
        if (count == '0) begin
          fin.valid  = 1'b1;
          fin.out_id = oid;
          state_next = S_IDLE;
        end else begin
          state_next = S_DN_RDL;
        end
      end

      // sift-down: fetch left child, or settle at a leaf
      S_DN_RDL: begin
        if (lidx > cnt_w) begin
          mem.we     = 1'b1;
          fin.valid  = 1'b1;
          fin.out_id = oid;
          state_next = S_IDLE;
        end else begin
          mem.raddr  = lidx[IDXW-1:0];
          state_next = S_DN_RDR;
        end
      end

      // sift-down: hold left child, fetch right child if present
      S_DN_RDR: begin
        lft_next = rd_data;
        if (has_right) begin
          mem.raddr = ridx[IDXW-1:0];
        end
        state_next = S_DN_CMP;
      end

      // sift-down: larger child (right on a tie) moves up, or entry settles
      S_DN_CMP: begin
        mem.we = 1'b1;
        if (child.key > ent.key) begin
          mem.wdata  = child;
          pos_next   = use_right ? ridx[IDXW-1:0] : lidx[IDXW-1:0];
          state_next = S_DN_RDL;
        end else begin
          fin.valid  = 1'b1;
          fin.out_id = oid;
          state_next = S_IDLE;
        end
      end

      // modify: one slot read a cycle, compare the slot returned
      S_MD_SCAN: begin
        mem.raddr      = scan_addr;
        chk_valid_next = 1'b1;
        chk_addr_next  = scan_addr;
        if (scan_addr != count) begin
          scan_addr_next = scan_addr + 1'b1;
        end
        if (chk_valid && (rd_data.id == req_id)) begin
          pos_next     = chk_addr;
          ent_next.id  = req_id;
          ent_next.key = req_key;
          state_next   = S_UP_RD;
        end else if (chk_valid && (chk_addr == count)) begin
          fin.valid  = 1'b1;
          fin.status = ST_NOTFOUND;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/indexed_max_heap.sv]
// Indexed max-heap priority queue: top level with slot store and result register.
//
// A command word is taken when start is high and busy is low. Each command
// gives one result word on result, marked by done for one cycle, in the cycle
// after the command completes; the receiver cannot hold it off, and a new
// command may be taken in that same cycle. Errors and the unused code finish
// at once (result in the cycle after start). Insert reads the parent and
// compares it in each level of sift-up (S_UP_RD, S_UP_CMP), then writes the
// entry where it settles. Extract fetches root and last entry (S_EX_ROOT,
// S_EX_LAST, S_EX_LOAD), then reads left child, right child and compares in
// each level of sift-down (S_DN_RDL, S_DN_RDR, S_DN_CMP) until it settles.
// Modify walks the slots at one per cycle, then sifts up as insert does. The
// steps are set by the single read port of the slot store and its registered read data.
`default_nettype none
module indexed_max_heap import ihp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire ihp_in_t  cmd,
  output logic          done,
  output ihp_out_t      result
);

  logic         idle;
  logic         accept;
  ihp_mem_req_t mem;
  ihp_fin_t     fin;
  ihp_entry_t   rd_data;

  assign busy   = !idle;
  assign accept = start && idle;

  ihp_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .cmd     (cmd),
    .rd_data (rd_data),
    .idle    (idle),
    .mem     (mem),
    .fin     (fin)
  );

  ihp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rd_data)
  );

  // result word and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
    result.out_id <= fin.out_id;
    result.status <= fin.status;
    result.fill   <= fin.fill;
  end

endmodule
`default_nettype wire

[rtl/ihp_checker.sv]
// Port-level checks for the indexed max-heap, bound to the top level.
`default_nettype none
module ihp_port_checks import ihp_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire ihp_in_t  cmd,
  input wire logic     done,
  input wire ihp_out_t result
);

  // a taken command is either still at work or answered next cycle
  a_taken_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("command neither in progress nor answered");

  // fill never exceeds the heap size
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.fill <= FILL_W'(CAPACITY)))
    else $error("fill beyond capacity");

  // a result with an error status returns no id
  a_err_no_id: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_OK)) |-> (result.out_id == '0))
    else $error("id returned with an error status");

  // empty and full reports agree with fill
  a_err_fill: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.status != ST_EMPTY) || (result.fill == '0)) &&
             ((result.status != ST_FULL) || (result.fill == FILL_W'(CAPACITY))))
    else $error("error status disagrees with fill");

endmodule

bind indexed_max_heap ihp_port_checks u_ihp_checker (.*);
`default_nettype wire
